// ===== rtl/kapr_pkg.sv =====
// ----------------------------------------------------------------------------
// kapr_pkg
// Shared types and constants for the keyframe-aligned frame ring: field
// widths, operation and status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kapr_pkg;

   // Field widths
   localparam int OP_W     = 2;
   localparam int HANDLE_W = 32;
   localparam int SIZE_W   = 24;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 3;

   // Stream payload widths
   localparam int REQ_DATA_W = 120;  // handle, size, now, span = 120 bits
   localparam int REQ_USER_W = 3;    // operation, keyframe flag
   localparam int RSP_DATA_W = 56;   // handle, size = 56 bits
   localparam int RSP_USER_W = 3;    // status

   // Results per input item and the width of their counter
   localparam int MAX_RESULTS = 33;
   localparam int NRES_W      = 6;

   // Defaults
   localparam int                DEF_RING_DEPTH = 32;
   localparam logic [TIME_W-1:0] WINDOW_RESET   = 32'd10000;

   // Operation codes (code 3 is unused and ignored)
   typedef enum logic [OP_W-1:0] {
      OP_PUSH    = 2'd0,
      OP_EVICT   = 2'd1,
      OP_EXTRACT = 2'd2
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_PUSH_DONE  = 3'd0,
      ST_AGED_OUT   = 3'd1,
      ST_OVERFLOW   = 3'd2,
      ST_EVICTED    = 3'd3,
      ST_BACKFILL   = 3'd4,
      ST_RING_EMPTY = 3'd5,
      ST_NO_KEY     = 3'd6
   } status_type;

   // Where the payload of an emitted result comes from
   typedef enum logic [1:0] {
      SRC_ENTRY,         // stored handle and size
      SRC_ENTRY_HANDLE,  // stored handle, size zero
      SRC_ITEM,          // handle of the current item, size zero
      SRC_ZERO           // all zero
   } emit_src_type;

   // One stored descriptor
   typedef struct packed {
      logic                key;
      logic [SIZE_W-1:0]   size;
      logic [TIME_W-1:0]   stamp;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller states
   typedef enum logic [4:0] {
      CS_IDLE,
      CS_DISPATCH,
      CS_DROP_RD,
      CS_DROP_EMIT,
      CS_WRITE,
      CS_AGE_RD,
      CS_AGE_CHK,
      CS_DONE_EMIT,
      CS_EVICT_RD,
      CS_EVICT_EMIT,
      CS_EMPTY_EMIT,
      CS_SCAN_RD,
      CS_SCAN_CHK,
      CS_KEY_RD,
      CS_KEY_CHK,
      CS_OUT_RD,
      CS_OUT_EMIT,
      CS_NOKEY_EMIT
   } ctl_state_type;

   // Controller to datapath
   typedef struct packed {
      logic         load_item;
      logic         n_clear;
      logic         rd_oldest;
      logic         rd_idx;
      logic         wr_new;
      logic         pop;
      logic         i_clear;
      logic         i_inc;
      logic         i_dec;
      logic         emit;
      emit_src_type src;
      status_type   code;
      logic         last;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            age_over;
      logic            span_over;
      logic            key_mark;
      logic            i_zero;
      logic            i_last;
      logic            n_below_cap;
      logic            out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/kapr_ram.sv =====
// ----------------------------------------------------------------------------
// kapr_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module kapr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/kapr_datapath.sv =====
// ----------------------------------------------------------------------------
// kapr_datapath
// Descriptor RAM, ring pointers, window register, item capture, walk index,
// result counter and the output register of the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module kapr_datapath #(
   parameter int RING_DEPTH = kapr_pkg::DEF_RING_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // item fields
   input  wire logic [kapr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic [kapr_pkg::REQ_USER_W-1:0] req_tuser,
   // configuration
   input  wire logic                            csr_wr_en,
   input  wire logic [kapr_pkg::TIME_W-1:0]     csr_wr_data,
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [kapr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic      [kapr_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                                 rsp_tlast,
   // controller link
   input  wire kapr_pkg::cmd_type               cmd,
   output kapr_pkg::sts_type                    sts
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;

   // (base + offset) mod depth; both terms stay below the depth
   function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(RING_DEPTH)) begin
         sum = sum - SUM_W'(RING_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // ring state
   logic [IDX_W-1:0]              oldest_ff, oldest_in;
   logic [CNT_W-1:0]              count_ff,  count_in;
   logic [kapr_pkg::TIME_W-1:0]   window_ff, window_in;

   // captured item
   logic [kapr_pkg::OP_W-1:0]     op_ff;
   logic [kapr_pkg::HANDLE_W-1:0] handle_ff;
   logic                          key_ff;
   logic [kapr_pkg::SIZE_W-1:0]   size_ff;
   logic [kapr_pkg::TIME_W-1:0]   now_ff;
   logic [kapr_pkg::TIME_W-1:0]   span_ff;

   // walk index and result counter
   logic [CNT_W-1:0]              i_ff, i_in;
   logic [kapr_pkg::NRES_W-1:0]   n_ff, n_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [kapr_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [kapr_pkg::HANDLE_W-1:0] rsp_handle_ff;
   logic [kapr_pkg::SIZE_W-1:0]   rsp_size_ff;
   logic                          rsp_last_ff;

   // RAM ports
   kapr_pkg::entry_type           wr_entry;
   kapr_pkg::entry_type           rd_entry;
   logic [kapr_pkg::ENTRY_W-1:0]  rd_word;
   logic [IDX_W-1:0]              wr_addr;
   logic [IDX_W-1:0]              rd_addr;
   logic                          rd_en;

   // age arithmetic on the entry just read
   logic [kapr_pkg::TIME_W-1:0]   age;

   // payload of a result about to be emitted
   logic [kapr_pkg::HANDLE_W-1:0] emit_handle;
   logic [kapr_pkg::SIZE_W-1:0]   emit_size;

   // descriptor store
   assign wr_entry.key    = key_ff;
   assign wr_entry.size   = size_ff;
   assign wr_entry.stamp  = now_ff;
   assign wr_entry.handle = handle_ff;
   assign wr_addr         = slot_at(oldest_ff, count_ff);
   assign rd_addr         = cmd.rd_oldest ? oldest_ff : slot_at(oldest_ff, i_ff);
   assign rd_en           = cmd.rd_oldest | cmd.rd_idx;
   assign rd_entry        = kapr_pkg::entry_type'(rd_word);

   kapr_ram #(
      .WIDTH (kapr_pkg::ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_new),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   // ring pointers and window register
   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      window_in = window_ff;
      if (cmd.pop) begin
         oldest_in = (oldest_ff == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end else if (cmd.wr_new) begin
         count_in  = count_ff + 1'b1;
      end
      if (csr_wr_en) begin
         window_in = csr_wr_data;
      end
   end

   // walk index and result count
   always_comb begin
      i_in = i_ff;
      n_in = n_ff;
      if (cmd.i_clear) begin
         i_in = '0;
      end else if (cmd.i_inc) begin
         i_in = i_ff + 1'b1;
      end else if (cmd.i_dec) begin
         i_in = i_ff - 1'b1;
      end
      if (cmd.n_clear) begin
         n_in = '0;
      end else if (cmd.emit) begin
         n_in = n_ff + 1'b1;
      end
   end

   // result payload select
   always_comb begin
      unique case (cmd.src)
         kapr_pkg::SRC_ENTRY: begin
            emit_handle = rd_entry.handle;
            emit_size   = rd_entry.size;
         end
         kapr_pkg::SRC_ENTRY_HANDLE: begin
            emit_handle = rd_entry.handle;
            emit_size   = '0;
         end
         kapr_pkg::SRC_ITEM: begin
            emit_handle = handle_ff;
            emit_size   = '0;
         end
         default: begin
            emit_handle = '0;
            emit_size   = '0;
         end
      endcase
   end

   // output register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff    <= '0;
         count_ff     <= '0;
         window_ff    <= kapr_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      i_ff <= i_in;
      n_ff <= n_in;
      if (cmd.load_item) begin
         op_ff     <= req_tuser[1:0];
         key_ff    <= req_tuser[2];
         handle_ff <= req_tdata[31:0];
         size_ff   <= req_tdata[55:32];
         now_ff    <= req_tdata[87:56];
         span_ff   <= req_tdata[119:88];
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.code;
         rsp_handle_ff <= emit_handle;
         rsp_size_ff   <= emit_size;
         rsp_last_ff   <= cmd.last;
      end
   end

   // status to the controller
   assign age             = now_ff - rd_entry.stamp;
   assign sts.op          = op_ff;
   assign sts.full        = (count_ff == CNT_W'(RING_DEPTH));
   assign sts.empty       = (count_ff == '0);
   assign sts.age_over    = (age > window_ff);
   assign sts.span_over   = (age > span_ff);
   assign sts.key_mark    = rd_entry.key;
   assign sts.i_zero      = (i_ff == '0);
   assign sts.i_last      = (CNT_W'(i_ff + 1'b1) == count_ff);
   assign sts.n_below_cap = (n_ff < kapr_pkg::NRES_W'(kapr_pkg::MAX_RESULTS - 1));
   assign sts.out_free    = ~rsp_valid_ff | rsp_tready;

   // result stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_size_ff, rsp_handle_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/kapr_controller.sv =====
// ----------------------------------------------------------------------------
// kapr_controller
// Sequencer for push, evict and extract: walks the ring one entry per read,
// decides on each entry read and issues emit commands when the output
// register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module kapr_controller (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire kapr_pkg::sts_type sts,
   output kapr_pkg::cmd_type      cmd
);

   kapr_pkg::ctl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kapr_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kapr_pkg::CS_IDLE: begin
            if (req_tvalid) state_in = kapr_pkg::CS_DISPATCH;
         end
         kapr_pkg::CS_DISPATCH: begin
            unique case (sts.op)
               kapr_pkg::OP_PUSH:
                  state_in = sts.full ? kapr_pkg::CS_DROP_RD : kapr_pkg::CS_WRITE;
               kapr_pkg::OP_EVICT:
                  state_in = sts.empty ? kapr_pkg::CS_EMPTY_EMIT : kapr_pkg::CS_EVICT_RD;
               kapr_pkg::OP_EXTRACT:
                  state_in = sts.empty ? kapr_pkg::CS_EMPTY_EMIT : kapr_pkg::CS_SCAN_RD;
               default:
                  state_in = kapr_pkg::CS_IDLE;
            endcase
         end
         kapr_pkg::CS_DROP_RD:   state_in = kapr_pkg::CS_DROP_EMIT;
         kapr_pkg::CS_DROP_EMIT: begin
            if (sts.out_free) state_in = kapr_pkg::CS_WRITE;
         end
         kapr_pkg::CS_WRITE:     state_in = kapr_pkg::CS_AGE_RD;
         kapr_pkg::CS_AGE_RD:    state_in = kapr_pkg::CS_AGE_CHK;
         kapr_pkg::CS_AGE_CHK: begin
            priority if (!sts.age_over) begin
               state_in = kapr_pkg::CS_DONE_EMIT;
            end else if (!sts.n_below_cap || sts.out_free) begin
               state_in = kapr_pkg::CS_AGE_RD;
            end else begin
               state_in = kapr_pkg::CS_AGE_CHK;
            end
         end
         kapr_pkg::CS_DONE_EMIT,
         kapr_pkg::CS_EVICT_EMIT,
         kapr_pkg::CS_EMPTY_EMIT,
         kapr_pkg::CS_NOKEY_EMIT: begin
            if (sts.out_free) state_in = kapr_pkg::CS_IDLE;
         end
         kapr_pkg::CS_EVICT_RD:  state_in = kapr_pkg::CS_EVICT_EMIT;
         kapr_pkg::CS_SCAN_RD:   state_in = kapr_pkg::CS_SCAN_CHK;
         kapr_pkg::CS_SCAN_CHK: begin
            // past the newest entry: fall back to the newest, already read
            if (sts.span_over && !sts.i_last) state_in = kapr_pkg::CS_SCAN_RD;
            else                              state_in = kapr_pkg::CS_KEY_CHK;
         end
         kapr_pkg::CS_KEY_RD:    state_in = kapr_pkg::CS_KEY_CHK;
         kapr_pkg::CS_KEY_CHK: begin
            priority if (sts.key_mark) state_in = kapr_pkg::CS_OUT_EMIT;
            else if (!sts.i_zero)      state_in = kapr_pkg::CS_KEY_RD;
            else                       state_in = kapr_pkg::CS_NOKEY_EMIT;
         end
         kapr_pkg::CS_OUT_RD:    state_in = kapr_pkg::CS_OUT_EMIT;
         kapr_pkg::CS_OUT_EMIT: begin
            if (sts.out_free) begin
               if (sts.i_last || !sts.n_below_cap) state_in = kapr_pkg::CS_IDLE;
               else                                state_in = kapr_pkg::CS_OUT_RD;
            end
         end
         default: state_in = kapr_pkg::CS_IDLE;
      endcase
   end

   // command outputs
   always_comb begin
      cmd        = '0;
      cmd.src    = kapr_pkg::SRC_ZERO;
      cmd.code   = kapr_pkg::ST_PUSH_DONE;
      req_tready = 1'b0;
      unique case (state_ff)
         kapr_pkg::CS_IDLE: begin
            // no beat is taken while reset is held
            req_tready    = ~reset;
            cmd.load_item = req_tvalid;
            cmd.n_clear   = req_tvalid;
         end
         kapr_pkg::CS_DISPATCH: begin
            cmd.i_clear = 1'b1;
         end
         kapr_pkg::CS_DROP_RD,
         kapr_pkg::CS_AGE_RD,
         kapr_pkg::CS_EVICT_RD: begin
            cmd.rd_oldest = 1'b1;
         end
         kapr_pkg::CS_DROP_EMIT: begin
            cmd.emit = sts.out_free;
            cmd.pop  = sts.out_free;
            cmd.src  = kapr_pkg::SRC_ENTRY;
            cmd.code = kapr_pkg::ST_OVERFLOW;
         end
         kapr_pkg::CS_WRITE: begin
            cmd.wr_new = 1'b1;
         end
         kapr_pkg::CS_AGE_CHK: begin
            // releases past the result cap are popped silently
            cmd.src  = kapr_pkg::SRC_ENTRY;
            cmd.code = kapr_pkg::ST_AGED_OUT;
            if (sts.age_over) begin
               cmd.emit = sts.n_below_cap & sts.out_free;
               cmd.pop  = ~sts.n_below_cap | sts.out_free;
            end
         end
         kapr_pkg::CS_DONE_EMIT: begin
            cmd.emit = sts.out_free;
            cmd.src  = kapr_pkg::SRC_ITEM;
            cmd.code = kapr_pkg::ST_PUSH_DONE;
            cmd.last = 1'b1;
         end
         kapr_pkg::CS_EVICT_EMIT: begin
            cmd.emit = sts.out_free;
            cmd.pop  = sts.out_free;
            cmd.src  = kapr_pkg::SRC_ENTRY;
            cmd.code = kapr_pkg::ST_EVICTED;
            cmd.last = 1'b1;
         end
         kapr_pkg::CS_EMPTY_EMIT: begin
            cmd.emit = sts.out_free;
            cmd.code = kapr_pkg::ST_RING_EMPTY;
            cmd.last = 1'b1;
         end
         kapr_pkg::CS_NOKEY_EMIT: begin
            cmd.emit = sts.out_free;
            cmd.code = kapr_pkg::ST_NO_KEY;
            cmd.last = 1'b1;
         end
         kapr_pkg::CS_SCAN_RD,
         kapr_pkg::CS_KEY_RD,
         kapr_pkg::CS_OUT_RD: begin
            cmd.rd_idx = 1'b1;
         end
         kapr_pkg::CS_SCAN_CHK: begin
            cmd.i_inc = sts.span_over & ~sts.i_last;
         end
         kapr_pkg::CS_KEY_CHK: begin
            cmd.i_dec = ~sts.key_mark & ~sts.i_zero;
         end
         kapr_pkg::CS_OUT_EMIT: begin
            cmd.emit  = sts.out_free;
            cmd.src   = kapr_pkg::SRC_ENTRY_HANDLE;
            cmd.code  = kapr_pkg::ST_BACKFILL;
            cmd.last  = sts.i_last | ~sts.n_below_cap;
            cmd.i_inc = sts.out_free & ~sts.i_last & sts.n_below_cap;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/keyframe_aligned_prebuffer_ring_unit.sv =====
// ----------------------------------------------------------------------------
// keyframe_aligned_prebuffer_ring_unit
// Ring of frame descriptors with a time window: push with overflow drop and
// age-out, evict of the oldest entry, and keyframe-aligned backfill extract.
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: handle, size, now, span
//                                       tuser: operation, keyframe flag
//   rsp      out  rsp_tvalid/tready     tdata: handle, size; tuser: status;
//                                       tlast: last result of the item
//   csr      in   csr_wr_en             csr_wr_data: window span
//
// One item at a time; req_tready is high only between items. Each entry
// visited is read on the single read port of the descriptor RAM, then
// checked or emitted: push drops on overflow, writes, then releases aged
// entries; extract scans, steps back to a keyframe and emits the backfill.
// A stalled rsp holds the walk at its next result. Reset is synchronous;
// no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_aligned_prebuffer_ring_unit #(
   parameter int RING_DEPTH = kapr_pkg::DEF_RING_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // input stream
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [31:0] frame_handle, [55:32] frame_size, [87:56] now_time,
   // [119:88] backfill_span
   input  wire logic [kapr_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation, [2] keyframe flag
   input  wire logic [kapr_pkg::REQ_USER_W-1:0] req_tuser,
   // result stream
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [31:0] out_handle, [55:32] released_size
   output logic      [kapr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic      [kapr_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                                 rsp_tlast,
   // window span register
   input  wire logic                            csr_wr_en,
   input  wire logic [kapr_pkg::TIME_W-1:0]     csr_wr_data
);

   kapr_pkg::cmd_type cmd;
   kapr_pkg::sts_type sts;

   // sequencer
   kapr_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // storage and arithmetic
   kapr_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

`default_nettype wire

// ===== bench/keyframe_aligned_prebuffer_ring_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyframe_aligned_prebuffer_ring_unit_tb
// Self-checking bench for the frame ring. A shadow ring inside the bench
// predicts every result beat. Each accepted request updates the shadow ring,
// and each rsp beat is compared field by field with the oldest predicted
// beat. A short directed run covers the empty ring, ignored codes, time wrap,
// missing keyframes and age-out. Random phases then run under several
// window settings and idle patterns, one of them with a long rsp hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_aligned_prebuffer_ring_unit_tb;
   import kapr_pkg::*;

   localparam int          DEPTH          = DEF_RING_DEPTH;
   localparam logic [1:0]  OP_UNUSED      = 2'd3;
   localparam int          SETTLE_CYCLES  = 400;   // longer than the worst walk
   localparam int          HOLD_CYCLES    = 600;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] handle;
      logic        key;
      logic [23:0] size;
      logic [31:0] now;
      logic [31:0] span;
   } frame_req_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] handle;
      logic [23:0] size;
      logic        last;
   } ring_result_type;

   // Shadow copy of the ring and the queue of result beats still owed
   class ring_shadow;
      logic [31:0]     slot_handle [DEPTH];
      logic [31:0]     slot_time   [DEPTH];
      logic [23:0]     slot_size   [DEPTH];
      logic            slot_key    [DEPTH];
      int unsigned     oldest;
      int unsigned     total;
      logic [31:0]     window;
      ring_result_type due_results[$];
      ring_result_type run[$];
      int unsigned     mismatches;
      int unsigned     checked;
      int unsigned     requests;
      int unsigned     status_seen[7];

      function new();
         oldest = 0;
         total = 0;
         window = WINDOW_RESET;
         mismatches = 0;
         checked = 0;
         requests = 0;
         foreach (status_seen[k]) status_seen[k] = 0;
      endfunction

      function void set_window(logic [31:0] w);
         window = w;
      endfunction

      function int unsigned slot(int unsigned off);
         return (oldest + off) % DEPTH;
      endfunction

      function void add(status_type st, logic [31:0] h, logic [23:0] s);
         ring_result_type r;
         r.status = st;
         r.handle = h;
         r.size = s;
         r.last = 1'b0;
         run.insert(run.size(), r);
      endfunction

      function void drop_oldest();
         oldest = (oldest + 1) % DEPTH;
         total--;
      endfunction

      // Work out the beats one accepted request causes
      function void apply_request(frame_req_type rq);
         int unsigned s;
         int unsigned i;
         logic [31:0] age;
         run.delete();
         requests++;
         case (rq.op)
            OP_PUSH: begin
               if (total >= DEPTH) begin
                  add(ST_OVERFLOW, slot_handle[oldest], slot_size[oldest]);
                  drop_oldest();
               end
               s = slot(total);
               slot_handle[s] = rq.handle;
               slot_time[s] = rq.now;
               slot_size[s] = rq.size;
               slot_key[s] = rq.key;
               total++;
               // release from the oldest while past the window
               while (total > 0) begin
                  age = rq.now - slot_time[oldest];
                  if (age <= window) break;
                  if (run.size() < MAX_RESULTS - 1)
                     add(ST_AGED_OUT, slot_handle[oldest], slot_size[oldest]);
                  drop_oldest();
               end
               add(ST_PUSH_DONE, rq.handle, '0);
            end
            OP_EVICT: begin
               if (total == 0) begin
                  add(ST_RING_EMPTY, '0, '0);
               end else begin
                  add(ST_EVICTED, slot_handle[oldest], slot_size[oldest]);
                  drop_oldest();
               end
            end
            OP_EXTRACT: begin
               if (total == 0) begin
                  add(ST_RING_EMPTY, '0, '0);
               end else begin
                  // first entry inside the span, else the newest
                  i = 0;
                  while (i < total) begin
                     age = rq.now - slot_time[slot(i)];
                     if (age <= rq.span) break;
                     i++;
                  end
                  if (i >= total) i = total - 1;
                  // step back to a keyframe
                  while (i > 0 && !slot_key[slot(i)]) i--;
                  if (!slot_key[slot(i)]) begin
                     add(ST_NO_KEY, '0, '0);
                  end else begin
                     while (i < total && run.size() < MAX_RESULTS) begin
                        add(ST_BACKFILL, slot_handle[slot(i)], '0);
                        i++;
                     end
                  end
               end
            end
            default: ;  // unused code, ignored
         endcase
         if (run.size() > 0) run[run.size() - 1].last = 1'b1;
         foreach (run[k]) due_results.insert(due_results.size(), run[k]);
      endfunction

      function void report(string what, ring_result_type want, ring_result_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%t %s: expected st=%0d h=%h sz=%h last=%b, got st=%0d h=%h sz=%h last=%b",
                     $realtime, what, want.status, want.handle, want.size, want.last,
                     got.status, got.handle, got.size, got.last);
      endfunction

      function void check_result(ring_result_type got);
         ring_result_type want;
         if (got.status <= ST_NO_KEY) status_seen[got.status]++;
         if (due_results.size() == 0) begin
            report("unexpected beat", got, got);
            return;
         end
         want = due_results[0];
         due_results.delete(0);
         checked++;
         if (got.status !== want.status || got.handle !== want.handle ||
             got.size !== want.size || got.last !== want.last)
            report("mismatch", want, got);
      endfunction

      function void flush_leftovers();
         ring_result_type want;
         while (due_results.size() > 0) begin
            want = due_results[0];
            due_results.delete(0);
            report("missing beat", want, want);
         end
      endfunction
   endclass

   // DUT signals; the ones the bench drives are known from time zero
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_wr_en = 1'b0;
   logic [TIME_W-1:0]     csr_wr_data = '0;

   ring_shadow  shadow = new();
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_asked = 0;
   int unsigned hold_taken = 0;
   int unsigned hold_left = 0;
   int unsigned quiet_cycles = 0;
   logic [31:0] now_ms = '0;

   keyframe_aligned_prebuffer_ring_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result beat checker
   always @(posedge clock) begin
      ring_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = status_type'(rsp_tuser);
         got.handle = rsp_tdata[31:0];
         got.size = rsp_tdata[55:32];
         got.last = rsp_tlast;
         shadow.check_result(got);
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic frame_req_type make_req(logic [1:0] op, logic [31:0] handle,
                                              logic key, logic [23:0] size,
                                              logic [31:0] now, logic [31:0] span);
      frame_req_type rq;
      rq.op = op;
      rq.handle = handle;
      rq.key = key;
      rq.size = size;
      rq.now = now;
      rq.span = span;
      return rq;
   endfunction

   // Mostly well-ordered time with random content; a few noise beats
   function automatic frame_req_type random_req(int unsigned step_max);
      frame_req_type rq;
      int unsigned   pick;
      int unsigned   sel;
      now_ms = now_ms + $urandom_range(step_max);
      rq.handle = $urandom();
      rq.size = 24'($urandom());
      rq.key = ($urandom_range(5) == 0);
      rq.now = now_ms;
      sel = $urandom_range(9);
      if (sel < 2) rq.span = '0;
      else if (sel == 2) rq.span = ALL_ONES;
      else if (sel == 3) rq.span = $urandom();
      else rq.span = $urandom_range(step_max) * 32'd8;
      pick = $urandom_range(99);
      if (pick < 5) begin
         rq.op = 2'($urandom_range(3));
         rq.now = $urandom();
      end else if (pick < 57) rq.op = OP_PUSH;
      else if (pick < 67) rq.op = OP_EVICT;
      else if (pick < 95) rq.op = OP_EXTRACT;
      else rq.op = OP_UNUSED;
      return rq;
   endfunction

   task automatic send_req(frame_req_type rq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rq.span, rq.now, rq.size, rq.handle};
      req_tuser <= {rq.key, rq.op};
      do @(posedge clock); while (!req_tready);
      shadow.apply_request(rq);
   endtask

   // Wait for all owed beats, then let a silent walk finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (shadow.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic [31:0] w);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= w;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow.set_window(w);
   endtask

   task automatic run_phase(logic [31:0] w, int unsigned step_max, int unsigned tx_idle,
                            int unsigned rx_stall, bit hold, logic [31:0] start_ms,
                            int unsigned count);
      write_window(w);
      send_idle_pct = tx_idle;
      recv_stall_pct = rx_stall;
      now_ms = start_ms;
      if (hold) hold_asked++;
      repeat (count) send_req(random_req(step_max));
   endtask

   localparam logic [31:0] T0 = 32'hFFFF_FFF0;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset window, empty ring, ignored code, time wrap, keyframes
      send_req(make_req(OP_EVICT, '0, 1'b0, '0, '0, '0));
      send_req(make_req(OP_EXTRACT, '0, 1'b0, '0, '0, ALL_ONES));
      send_req(make_req(OP_UNUSED, ALL_ONES, 1'b1, 24'hFF_FFFF, ALL_ONES, ALL_ONES));
      send_req(make_req(OP_PUSH, '0, 1'b0, '0, T0, '0));
      send_req(make_req(OP_EXTRACT, '0, 1'b0, '0, T0, '0));
      send_req(make_req(OP_PUSH, ALL_ONES, 1'b1, 24'hFF_FFFF, T0 + 5, '0));
      send_req(make_req(OP_PUSH, 32'h1234_5678, 1'b0, 24'h00_ABCD, 32'h3, '0));
      // nothing inside the span: start at the newest and step back
      send_req(make_req(OP_EXTRACT, '0, 1'b0, '0, 32'h10, '0));
      // start at the oldest delta frame: no keyframe behind it
      send_req(make_req(OP_EXTRACT, '0, 1'b0, '0, 32'h10, ALL_ONES));
      send_req(make_req(OP_PUSH, 32'h0000_00A5, 1'b1, 24'h1, 32'h20, '0));
      send_req(make_req(OP_EXTRACT, '0, 1'b0, '0, 32'h20, 32'h10));
      // far ahead in time: everything older ages out
      send_req(make_req(OP_PUSH, 32'h5A5A_0001, 1'b0, 24'h80_0000, 32'h20 + 20000, '0));
      send_req(make_req(OP_EVICT, '0, 1'b0, '0, '0, '0));
      send_req(make_req(OP_EVICT, '0, 1'b0, '0, '0, '0));

      // Random phases
      run_phase(32'd10000, 400, 0, 0, 1'b0, 32'hFFFF_F000, 80);
      run_phase(ALL_ONES, 5000, 83, 0, 1'b0, $urandom(), 80);
      run_phase('0, 1, 0, 83, 1'b0, $urandom(), 80);
      run_phase($urandom_range(3000, 100), 300, 19, 19, 1'b1, $urandom(), 80);
      run_phase($urandom(), ALL_ONES, 0, 0, 1'b0, $urandom(), 80);

      wait_idle();
      shadow.flush_leftovers();

      $display("Covered %0d requests and %0d result beats",
               shadow.requests, shadow.checked);
      $display("  windows 10000, all ones, zero, random; long rsp hold-off included");
      $display("Beats by status: done %0d aged %0d overflow %0d evicted %0d",
               shadow.status_seen[ST_PUSH_DONE], shadow.status_seen[ST_AGED_OUT],
               shadow.status_seen[ST_OVERFLOW], shadow.status_seen[ST_EVICTED]);
      $display("  backfill %0d empty %0d nokey %0d",
               shadow.status_seen[ST_BACKFILL], shadow.status_seen[ST_RING_EMPTY],
               shadow.status_seen[ST_NO_KEY]);
      if (shadow.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d failures", shadow.mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
